@@ rtl/rlc_pkg.sv @@
package rlc_pkg;

    localparam int CLIENTS     = 4;
    localparam int ORDER_SLOTS = 64;
    localparam int INSTR_SLOTS = 16;

    localparam int OSZ  = CLIENTS * ORDER_SLOTS;
    localparam int ISZ  = CLIENTS * INSTR_SLOTS;
    localparam int OA_W = $clog2(OSZ);
    localparam int IA_W = $clog2(ISZ);
    localparam int OC_W = $clog2(ORDER_SLOTS);
    localparam int IC_W = $clog2(INSTR_SLOTS);

    localparam int KEY_W  = 64;
    localparam int QTY_W  = 32;
    localparam int POS_W  = 40;
    localparam int CL_W   = 2;
    localparam int SIDE_W = 8;

    localparam int S_DATA_W = 208;
    localparam int M_DATA_W = 64;

    localparam logic [SIDE_W-1:0] SIDE_BUY  = 8'd66;
    localparam logic [SIDE_W-1:0] SIDE_SELL = 8'd83;

    typedef enum logic [1:0] {OP_NEW, OP_DEL, OP_MOD, OP_TRADE} op_t;
    typedef enum logic [1:0] {ST_ACC, ST_REJ, ST_NA, ST_FULL} status_t;
    typedef enum logic [0:0] {REG_BUY_LIMIT, REG_SELL_LIMIT} cfg_reg_t;

    typedef struct packed {
        logic [KEY_W-1:0] tag;
        logic [KEY_W-1:0] listing;
        logic [QTY_W-1:0] qty;
        logic             is_sell;
    } ord_rec_t;

    typedef struct packed {
        logic [KEY_W-1:0]        tag;
        logic [POS_W-1:0]        open_buy;
        logic [POS_W-1:0]        open_sell;
        logic signed [POS_W-1:0] net;
    } ins_rec_t;

    typedef struct packed {
        logic    load;
        logic    oscan_start;
        logic    oscan;
        logic    iscan_start;
        logic    iscan;
        logic    eval;
        logic    commit;
        logic    set_st;
        status_t st;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic client_ok;
        logic side_ok;
        logic o_last;
        logic i_last;
        logic ohit;
        logic ofree;
        logic out_busy;
    } dp_sts_t;

endpackage

@@ rtl/rlc_ram.sv @@
module rlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rlc_ctrl.sv @@
module rlc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rlc_pkg::dp_sts_t sts,
    output rlc_pkg::dp_cmd_t cmd
);
    import rlc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_OSCAN, S_OWAIT, S_ODEC,
        S_ISCAN, S_IWAIT, S_EVAL, S_COMMIT, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!sts.client_ok || (sts.op == OP_NEW && !sts.side_ok)) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NA;
                    state_next = S_DONE;
                end else begin
                    cmd.oscan_start = 1'b1;
                    state_next      = S_OSCAN;
                end
            end
            S_OSCAN: begin
                cmd.oscan = 1'b1;
                if (sts.o_last) begin
                    state_next = S_OWAIT;
                end
            end
            S_OWAIT: begin
                state_next = S_ODEC;
            end
            S_ODEC: begin
                if (sts.op == OP_NEW && sts.ohit) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_REJ;
                    state_next = S_DONE;
                end else if (sts.op == OP_NEW && !sts.ofree) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_FULL;
                    state_next = S_DONE;
                end else if (sts.op != OP_NEW && !sts.ohit) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NA;
                    state_next = S_DONE;
                end else begin
                    cmd.iscan_start = 1'b1;
                    state_next      = S_ISCAN;
                end
            end
            S_ISCAN: begin
                cmd.iscan = 1'b1;
                if (sts.i_last) begin
                    state_next = S_IWAIT;
                end
            end
            S_IWAIT: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

@@ rtl/rlc_datapath.sv @@
module rlc_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [rlc_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rlc_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [0:0]                       cfg_index,
    input  logic [rlc_pkg::POS_W-1:0]        cfg_data,
    input  rlc_pkg::dp_cmd_t                 cmd,
    output rlc_pkg::dp_sts_t                 sts
);
    import rlc_pkg::*;

    op_t                      op_reg;
    logic [CL_W-1:0]          client_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [KEY_W-1:0]         lst_reg;
    logic [SIDE_W-1:0]        side_reg;
    logic [QTY_W-1:0]         qty_reg;
    logic signed [QTY_W-1:0]  tq_reg;
    logic [POS_W-1:0]         buy_lim_reg;
    logic [POS_W-1:0]         sell_lim_reg;
    status_t                  st_reg;

    logic                     m_valid_reg;
    logic [KEY_W-1:0]         m_key_reg;
    status_t                  m_st_reg;

    logic [OSZ-1:0]           ovld_reg;
    logic [OC_W-1:0]          ocnt_reg;
    logic                     opv_reg;
    logic [OC_W-1:0]          opidx_reg;
    logic                     ohit_reg;
    logic [OC_W-1:0]          ohit_idx_reg;
    logic                     ofree_reg;
    logic [OC_W-1:0]          ofree_idx_reg;
    ord_rec_t                 orec_reg;

    logic [ISZ-1:0]           ivld_reg;
    logic [IC_W-1:0]          icnt_reg;
    logic                     ipv_reg;
    logic [IC_W-1:0]          ipidx_reg;
    logic                     ihit_reg;
    logic [IC_W-1:0]          ihit_idx_reg;
    logic                     ifree_reg;
    logic [IC_W-1:0]          ifree_idx_reg;
    ins_rec_t                 irec_reg;
    logic [KEY_W-1:0]         ikey_reg;

    logic                     sell_reg;
    logic                     up_reg;
    logic [POS_W:0]           t_reg;
    logic signed [POS_W+2:0]  v_reg;
    logic [POS_W-1:0]         low_reg;
    logic signed [POS_W-1:0]  nsum_reg;
    ins_rec_t                 brec_reg;

    logic [OA_W-1:0]          obase;
    logic [IA_W-1:0]          ibase;
    logic [OA_W-1:0]          o_raddr;
    logic [IA_W-1:0]          i_raddr;
    logic [OA_W-1:0]          o_cmp_addr;
    logic [IA_W-1:0]          i_cmp_addr;
    ord_rec_t                 ord_rd;
    ins_rec_t                 ins_rd;

    ins_rec_t                 brec;
    logic                     sell;
    logic [POS_W-1:0]         open;
    logic [QTY_W-1:0]         oldq;
    logic [QTY_W-1:0]         inc;
    logic [QTY_W-1:0]         dec;
    logic [POS_W:0]           t_calc;
    logic signed [POS_W+2:0]  netx;
    logic signed [POS_W+2:0]  v_calc;
    logic signed [POS_W:0]    nsum_wide;

    logic signed [POS_W+2:0]  tx;
    logic signed [POS_W+2:0]  worst;
    logic [POS_W-1:0]         lim;
    logic                     over;
    logic                     fail_full;
    logic [IC_W-1:0]          e_idx;
    ins_rec_t                 nrec;
    logic                     iwe;
    logic [IA_W-1:0]          iwaddr;
    logic                     owe;
    logic [OA_W-1:0]          owaddr;
    ord_rec_t                 owdata;
    logic                     oset;
    logic                     oclr;
    status_t                  cst;

    assign obase      = OA_W'(OA_W'(client_reg) * OA_W'(ORDER_SLOTS));
    assign ibase      = IA_W'(IA_W'(client_reg) * IA_W'(INSTR_SLOTS));
    assign o_raddr    = OA_W'(obase + OA_W'(ocnt_reg));
    assign i_raddr    = IA_W'(ibase + IA_W'(icnt_reg));
    assign o_cmp_addr = OA_W'(obase + OA_W'(opidx_reg));
    assign i_cmp_addr = IA_W'(ibase + IA_W'(ipidx_reg));

    rlc_ram #(.WIDTH($bits(ord_rec_t)), .DEPTH(OSZ)) u_ord_ram (
        .aclk  (aclk),
        .we    (owe),
        .waddr (owaddr),
        .wdata (owdata),
        .raddr (o_raddr),
        .rdata (ord_rd)
    );

    rlc_ram #(.WIDTH($bits(ins_rec_t)), .DEPTH(ISZ)) u_ins_ram (
        .aclk  (aclk),
        .we    (iwe),
        .waddr (iwaddr),
        .wdata (nrec),
        .raddr (i_raddr),
        .rdata (ins_rd)
    );

    always_comb begin
        brec = irec_reg;
        if (!ihit_reg) begin
            brec     = '0;
            brec.tag = ikey_reg;
        end
        sell      = (op_reg == OP_NEW) ? (side_reg == SIDE_SELL) : orec_reg.is_sell;
        open      = sell ? brec.open_sell : brec.open_buy;
        oldq      = orec_reg.qty;
        inc       = (op_reg == OP_NEW) ? qty_reg : qty_reg - oldq;
        dec       = (op_reg == OP_DEL) ? oldq : oldq - qty_reg;
        t_calc    = {1'b0, open} + (POS_W+1)'(inc);
        netx      = (POS_W+3)'(brec.net);
        v_calc    = $signed({2'b00, t_calc}) + (sell ? -netx : netx);
        nsum_wide = (POS_W+1)'(brec.net) + (POS_W+1)'(tq_reg);
    end

    always_comb begin
        tx        = $signed({2'b00, t_reg});
        worst     = (v_reg > tx) ? v_reg : tx;
        lim       = sell_reg ? sell_lim_reg : buy_lim_reg;
        over      = worst > $signed({3'b000, lim});
        fail_full = (op_reg == OP_NEW || op_reg == OP_TRADE) && !ihit_reg && !ifree_reg;
        e_idx     = ihit_reg ? ihit_idx_reg : ifree_idx_reg;
        iwaddr    = IA_W'(ibase + IA_W'(e_idx));
        nrec      = brec_reg;
        iwe       = 1'b0;
        owe       = 1'b0;
        owaddr    = OA_W'(obase + OA_W'(ohit_idx_reg));
        owdata    = orec_reg;
        oset      = 1'b0;
        oclr      = 1'b0;
        cst       = ST_NA;
        case (op_reg)
            OP_NEW: begin
                if (fail_full) begin
                    cst = ST_FULL;
                end else if (over) begin
                    cst = ST_REJ;
                end else begin
                    cst = ST_ACC;
                    iwe = 1'b1;
                    if (sell_reg) begin
                        nrec.open_sell = t_reg[POS_W-1:0];
                    end else begin
                        nrec.open_buy = t_reg[POS_W-1:0];
                    end
                    owe            = 1'b1;
                    oset           = 1'b1;
                    owaddr         = OA_W'(obase + OA_W'(ofree_idx_reg));
                    owdata.tag     = key_reg;
                    owdata.listing = lst_reg;
                    owdata.qty     = qty_reg;
                    owdata.is_sell = sell_reg;
                end
            end
            OP_DEL: begin
                cst  = ST_NA;
                oclr = 1'b1;
                if (ihit_reg) begin
                    iwe = 1'b1;
                    if (sell_reg) begin
                        nrec.open_sell = low_reg;
                    end else begin
                        nrec.open_buy = low_reg;
                    end
                end
            end
            OP_MOD: begin
                if (!ihit_reg) begin
                    cst = ST_NA;
                end else if (up_reg && over) begin
                    cst = ST_REJ;
                end else begin
                    cst        = ST_ACC;
                    iwe        = 1'b1;
                    owe        = 1'b1;
                    owdata.qty = qty_reg;
                    if (sell_reg) begin
                        nrec.open_sell = up_reg ? t_reg[POS_W-1:0] : low_reg;
                    end else begin
                        nrec.open_buy = up_reg ? t_reg[POS_W-1:0] : low_reg;
                    end
                end
            end
            OP_TRADE: begin
                if (fail_full) begin
                    cst = ST_FULL;
                end else begin
                    cst      = ST_NA;
                    iwe      = 1'b1;
                    nrec.net = nsum_reg;
                end
            end
            default: begin
                cst = ST_NA;
            end
        endcase
        if (!cmd.commit) begin
            iwe  = 1'b0;
            owe  = 1'b0;
            oset = 1'b0;
            oclr = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= op_t'(s_tuser);
            client_reg <= s_tdata[1:0];
            key_reg    <= s_tdata[65:2];
            lst_reg    <= s_tdata[129:66];
            side_reg   <= s_tdata[137:130];
            qty_reg    <= s_tdata[169:138];
            tq_reg     <= $signed(s_tdata[201:170]);
        end
        if (cmd.iscan_start) begin
            ikey_reg <= (op_reg == OP_NEW || op_reg == OP_TRADE) ? lst_reg : orec_reg.listing;
        end
        if (cmd.eval) begin
            sell_reg <= sell;
            up_reg   <= (op_reg == OP_NEW) || (qty_reg > oldq);
            t_reg    <= t_calc;
            v_reg    <= v_calc;
            low_reg  <= (open >= POS_W'(dec)) ? open - POS_W'(dec) : '0;
            brec_reg <= brec;
            if (nsum_wide[POS_W] != nsum_wide[POS_W-1]) begin
                nsum_reg <= nsum_wide[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                             : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                nsum_reg <= nsum_wide[POS_W-1:0];
            end
        end
        opidx_reg <= ocnt_reg;
        ipidx_reg <= icnt_reg;
        if (opv_reg && ovld_reg[o_cmp_addr] && ord_rd.tag == key_reg && !ohit_reg) begin
            ohit_idx_reg <= opidx_reg;
            orec_reg     <= ord_rd;
        end
        if (opv_reg && !ovld_reg[o_cmp_addr] && !ofree_reg) begin
            ofree_idx_reg <= opidx_reg;
        end
        if (ipv_reg && ivld_reg[i_cmp_addr] && ins_rd.tag == ikey_reg && !ihit_reg) begin
            ihit_idx_reg <= ipidx_reg;
            irec_reg     <= ins_rd;
        end
        if (ipv_reg && !ivld_reg[i_cmp_addr] && !ifree_reg) begin
            ifree_idx_reg <= ipidx_reg;
        end
        if (cmd.out_load) begin
            m_key_reg <= key_reg;
            m_st_reg  <= st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buy_lim_reg  <= '0;
            sell_lim_reg <= '0;
            st_reg       <= ST_NA;
            m_valid_reg  <= 1'b0;
            ovld_reg     <= '0;
            ivld_reg     <= '0;
            ocnt_reg     <= '0;
            icnt_reg     <= '0;
            opv_reg      <= 1'b0;
            ipv_reg      <= 1'b0;
            ohit_reg     <= 1'b0;
            ofree_reg    <= 1'b0;
            ihit_reg     <= 1'b0;
            ifree_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_reg_t'(cfg_index) == REG_BUY_LIMIT) begin
                    buy_lim_reg <= cfg_data;
                end else begin
                    sell_lim_reg <= cfg_data;
                end
            end
            opv_reg <= cmd.oscan;
            ipv_reg <= cmd.iscan;
            if (cmd.oscan_start) begin
                ocnt_reg  <= '0;
                ohit_reg  <= 1'b0;
                ofree_reg <= 1'b0;
            end else if (cmd.oscan) begin
                ocnt_reg <= ocnt_reg + 1'b1;
            end
            if (cmd.iscan_start) begin
                icnt_reg  <= '0;
                ihit_reg  <= 1'b0;
                ifree_reg <= 1'b0;
            end else if (cmd.iscan) begin
                icnt_reg <= icnt_reg + 1'b1;
            end
            if (opv_reg && ovld_reg[o_cmp_addr] && ord_rd.tag == key_reg) begin
                ohit_reg <= 1'b1;
            end
            if (opv_reg && !ovld_reg[o_cmp_addr]) begin
                ofree_reg <= 1'b1;
            end
            if (ipv_reg && ivld_reg[i_cmp_addr] && ins_rd.tag == ikey_reg) begin
                ihit_reg <= 1'b1;
            end
            if (ipv_reg && !ivld_reg[i_cmp_addr]) begin
                ifree_reg <= 1'b1;
            end
            if (oset) begin
                ovld_reg[owaddr] <= 1'b1;
            end
            if (oclr) begin
                ovld_reg[OA_W'(obase + OA_W'(ohit_idx_reg))] <= 1'b0;
            end
            if (iwe) begin
                ivld_reg[iwaddr] <= 1'b1;
            end
            if (cmd.set_st) begin
                st_reg <= cmd.st;
            end else if (cmd.commit) begin
                st_reg <= cst;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_key_reg;
    assign m_tuser   = m_st_reg;

    always_comb begin
        sts           = '0;
        sts.op        = op_reg;
        sts.client_ok = int'(client_reg) < CLIENTS;
        sts.side_ok   = (side_reg == SIDE_BUY) || (side_reg == SIDE_SELL);
        sts.o_last    = ocnt_reg == OC_W'(ORDER_SLOTS - 1);
        sts.i_last    = icnt_reg == IC_W'(INSTR_SLOTS - 1);
        sts.ohit      = ohit_reg;
        sts.ofree     = ofree_reg;
        sts.out_busy  = m_valid_reg && !m_tready;
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_tready))
        else $error("Result loaded over an untaken transaction.");

    a_fresh_instr: assert property (@(posedge aclk) disable iff (!aresetn)
        (iwe && !ihit_reg) |-> !ivld_reg[iwaddr])
        else $error("New instrument entry placed over a live entry.");

    a_fresh_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (oset && op_reg == OP_NEW) |-> !ovld_reg[owaddr])
        else $error("New order placed over a live entry.");

    a_out_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("Result appeared without a load.");

endmodule

@@ rtl/pretrade_risk_limit_check_top.sv @@
// Channel  Direction  Payload
// s_       in         tuser: cmd; tdata: client_index, order_key, listing_key,
//                     side_byte, quantity, trade_quantity
// m_       out        tdata: order_key_out; tuser: status
// cfg_     in         cfg_index: register, cfg_data: 40 bit limit
//
// Transactions that pass the client and side check run tag scans of the order memory
// and, unless decided there, of the instrument memory, one entry per cycle.
// Reset clears all valid bits and the limits at once; no clearing pass is needed.
// A new input is taken while a finished result still waits on the m_ channel.
// A stalled m_ channel holds the next result in its final step.
module pretrade_risk_limit_check_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // client_index, order_key, listing_key, side_byte, quantity, trade_quantity
    input  logic [rlc_pkg::S_DATA_W-1:0] s_tdata,
    // cmd
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // order_key_out
    output logic [rlc_pkg::M_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]                   m_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [rlc_pkg::POS_W-1:0]    cfg_data
);
    import rlc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rlc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ sim/pretrade_risk_limit_check_top_test.sv @@
module pretrade_risk_limit_check_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rlc_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam longint NET_HI = 64'sh7F_FFFF_FFFF;
    localparam longint NET_LO = -64'sh80_0000_0000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [POS_W-1:0] cfg_data = '0;

    typedef struct {
        logic [KEY_W-1:0] key;
        status_t st;
    } verdict_t;

    verdict_t verdicts[$];
    int errors = 0;
    int sink_gap = 0;
    longint cycles = 0;

    // Predictor state, flat arrays over all clients' slots as in the block.
    bit [KEY_W-1:0] lim_buy, lim_sell;
    bit o_live[OSZ];
    bit [KEY_W-1:0] o_key[OSZ];
    bit [KEY_W-1:0] o_lst[OSZ];
    bit [QTY_W-1:0] o_qty[OSZ];
    bit o_sell[OSZ];
    bit i_live[ISZ];
    bit [KEY_W-1:0] i_key[ISZ];
    longint i_buy[ISZ];
    longint i_sell[ISZ];
    longint i_net[ISZ];

    pretrade_risk_limit_check_top u_dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pretrade_risk_limit_check_top regression: fail");
            $finish;
        end
    end

    function automatic int find_order(int base, bit [KEY_W-1:0] key, bit want_free);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (want_free ? !o_live[base+i] : (o_live[base+i] && o_key[base+i] == key))
                return base + i;
        return -1;
    endfunction

    function automatic int find_instr(int base, bit [KEY_W-1:0] key, bit want_free);
        for (int i = 0; i < INSTR_SLOTS; i++)
            if (want_free ? !i_live[base+i] : (i_live[base+i] && i_key[base+i] == key))
                return base + i;
        return -1;
    endfunction

    function automatic bit fits(longint open, longint net, bit sell);
        longint v;
        v = sell ? open - net : open + net;
        if (v < open) v = open;
        return v <= longint'(sell ? lim_sell : lim_buy);
    endfunction

    function automatic void lower_open(int e, bit sell, longint d);
        if (sell) i_sell[e] = (i_sell[e] >= d) ? i_sell[e] - d : 0;
        else i_buy[e] = (i_buy[e] >= d) ? i_buy[e] - d : 0;
    endfunction

    function automatic status_t risk_verdict(op_t op, bit [1:0] cl, bit [KEY_W-1:0] key,
                                             bit [KEY_W-1:0] lst, bit [7:0] side,
                                             bit [31:0] q, bit [31:0] tq);
        int ob, ib, o, e;
        bit sell, fresh;
        longint open, net, t, n;
        ob = cl * ORDER_SLOTS;
        ib = cl * INSTR_SLOTS;
        open = 0;
        net = 0;
        fresh = 0;
        if (op == OP_NEW) begin
            if (side != SIDE_BUY && side != SIDE_SELL) return ST_NA;
            sell = (side == SIDE_SELL);
            if (find_order(ob, key, 0) >= 0) return ST_REJ;
            o = find_order(ob, 0, 1);
            if (o < 0) return ST_FULL;
            e = find_instr(ib, lst, 0);
            if (e < 0) begin
                e = find_instr(ib, 0, 1);
                if (e < 0) return ST_FULL;
                fresh = 1;
            end else begin
                open = sell ? i_sell[e] : i_buy[e];
                net = i_net[e];
            end
            if (!fits(open + q, net, sell)) return ST_REJ;
            if (fresh) begin
                i_live[e] = 1; i_key[e] = lst; i_buy[e] = 0; i_sell[e] = 0; i_net[e] = 0;
            end
            if (sell) i_sell[e] = (open + q) & 40'hFF_FFFF_FFFF;
            else i_buy[e] = (open + q) & 40'hFF_FFFF_FFFF;
            o_live[o] = 1; o_key[o] = key; o_lst[o] = lst; o_qty[o] = q; o_sell[o] = sell;
            return ST_ACC;
        end
        if (op != OP_TRADE) begin
            o = find_order(ob, key, 0);
            if (o < 0) return ST_NA;
            e = find_instr(ib, o_lst[o], 0);
            sell = o_sell[o];
            if (op == OP_DEL) begin
                if (e >= 0) lower_open(e, sell, o_qty[o]);
                o_live[o] = 0;
                return ST_NA;
            end
            if (e < 0) return ST_NA;
            if (q <= o_qty[o]) begin
                lower_open(e, sell, o_qty[o] - q);
            end else begin
                t = (sell ? i_sell[e] : i_buy[e]) + (q - o_qty[o]);
                if (!fits(t, i_net[e], sell)) return ST_REJ;
                if (sell) i_sell[e] = t & 40'hFF_FFFF_FFFF;
                else i_buy[e] = t & 40'hFF_FFFF_FFFF;
            end
            o_qty[o] = q;
            return ST_ACC;
        end
        if (find_order(ob, key, 0) < 0) return ST_NA;
        e = find_instr(ib, lst, 0);
        if (e < 0) begin
            e = find_instr(ib, 0, 1);
            if (e < 0) return ST_FULL;
            i_live[e] = 1; i_key[e] = lst; i_buy[e] = 0; i_sell[e] = 0; i_net[e] = 0;
        end
        n = i_net[e] + longint'($signed(tq));
        if (n > NET_HI) n = NET_HI;
        if (n < NET_LO) n = NET_LO;
        i_net[e] = n;
        return ST_NA;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_message(op_t op, bit [1:0] cl, bit [KEY_W-1:0] key,
                                bit [KEY_W-1:0] lst, bit [7:0] side, bit [31:0] q,
                                bit [31:0] tq);
        verdict_t v;
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        v.key = key;
        v.st = risk_verdict(op, cl, key, lst, side, q, tq);
        verdicts.push_back(v);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {tq, q, side, lst, key, cl};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdicts.size() != 0) @(posedge aclk);
        wait_cycles(ORDER_SLOTS + INSTR_SLOTS + 20);
    endtask

    task automatic write_limit(cfg_reg_t idx, bit [POS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_BUY_LIMIT) lim_buy = val;
        else lim_sell = val;
    endtask

    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (verdicts.size() == 0) begin
                    $error("unexpected result key %h", m_tdata);
                    errors++;
                end else begin
                    v = verdicts.pop_front();
                    if (m_tdata !== v.key) begin
                        $error("order_key_out expected %h actual %h", v.key, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== v.st) begin
                        $error("status expected %0d actual %0d", v.st, m_tuser);
                        errors++;
                    end
                end
                sink_gap = $urandom_range(0, 4);
            end else if (sink_gap != 0) begin
                sink_gap--;
            end
            m_tready <= (sink_gap == 0);
        end
    end

    function automatic bit [7:0] pick_side();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'($urandom);
        return r < 5 ? SIDE_BUY : SIDE_SELL;
    endfunction

    task automatic test_directed();
        write_limit(REG_BUY_LIMIT, 40'd1000);
        write_limit(REG_SELL_LIMIT, 40'd500);
        send_message(OP_NEW, 0, 64'd1, 64'd10, SIDE_BUY, 32'd600, 0);
        send_message(OP_NEW, 0, 64'd1, 64'd10, SIDE_BUY, 32'd1, 0);
        send_message(OP_NEW, 0, 64'd2, 64'd10, SIDE_BUY, 32'd401, 0);
        send_message(OP_NEW, 0, 64'd3, 64'd10, SIDE_SELL, 32'd500, 0);
        send_message(OP_NEW, 0, 64'd4, 64'd10, 8'hFF, 32'd1, 0);
        send_message(OP_NEW, 0, 64'd4, 64'd10, 8'h00, 32'd1, 0);
        send_message(OP_TRADE, 0, 64'd1, 64'd10, 0, 0, 32'd300);
        send_message(OP_MOD, 0, 64'd1, 0, 0, 32'd700, 0);
        send_message(OP_MOD, 0, 64'd1, 0, 0, 32'd200, 0);
        send_message(OP_MOD, 0, 64'd1, 0, 0, 32'd0, 0);
        send_message(OP_MOD, 0, 64'd99, 0, 0, 32'd5, 0);
        send_message(OP_DEL, 0, 64'd3, 0, 0, 0, 0);
        send_message(OP_DEL, 0, 64'd3, 0, 0, 0, 0);
        send_message(OP_TRADE, 0, 64'd77, 64'd10, 0, 0, 32'h8000_0000);
        send_message(OP_TRADE, 0, 64'd1, 64'd11, 0, 0, 32'h7FFF_FFFF);
        send_message(OP_TRADE, 3, '1, '1, 0, 0, 32'h8000_0000);
        send_message(OP_NEW, 3, '1, '1, SIDE_SELL, '1, '1);
        send_message(OP_NEW, 2, '1, '1, SIDE_BUY, '1, '1);
        send_message(OP_NEW, 1, 64'd0, 64'd0, SIDE_BUY, 32'd0, 0);
        drain();
        write_limit(REG_BUY_LIMIT, '1);
        write_limit(REG_SELL_LIMIT, '1);
        // Raise the net position with two large trades, then drive a large sell.
        send_message(OP_NEW, 2, 64'd5, 64'd50, SIDE_BUY, 32'd1, 0);
        for (int i = 0; i < 2; i++)
            send_message(OP_TRADE, 2, 64'd5, 64'd50, 0, 0, 32'h7FFF_FFFF);
        send_message(OP_NEW, 2, 64'd6, 64'd50, SIDE_SELL, '1, 0);
        drain();
    endtask

    task automatic test_fill_tables();
        write_limit(REG_BUY_LIMIT, '1);
        write_limit(REG_SELL_LIMIT, '1);
        for (int i = 0; i < ORDER_SLOTS + 2; i++)
            send_message(OP_NEW, 1, 64'h1000 + i, 64'(i % (INSTR_SLOTS + 3)), pick_side(),
                         $urandom, 0);
        for (int i = 0; i < INSTR_SLOTS + 2; i++)
            send_message(OP_TRADE, 1, 64'h1000 + i, 64'h500 + i, 0, 0, $urandom);
        for (int i = 0; i < ORDER_SLOTS + 2; i++)
            send_message(OP_DEL, 1, 64'h1000 + i, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_random(int count, bit [POS_W-1:0] lb, bit [POS_W-1:0] ls);
        op_t op;
        bit [1:0] cl;
        write_limit(REG_BUY_LIMIT, lb);
        write_limit(REG_SELL_LIMIT, ls);
        for (int i = 0; i < count; i++) begin
            op = op_t'($urandom_range(0, 3));
            cl = $urandom_range(0, 9) == 0 ? 2'($urandom) : 2'd0;
            if ($urandom_range(0, 19) == 0)
                send_message(op, cl, {$urandom, $urandom}, {$urandom, $urandom},
                             8'($urandom), $urandom, $urandom);
            else
                send_message(op, cl, 64'($urandom_range(0, 40)), 64'($urandom_range(0, 12)),
                             pick_side(), $urandom_range(0, 3) == 0 ? $urandom :
                             $urandom_range(0, 400), $urandom_range(0, 3) == 0 ? $urandom :
                             32'($signed($urandom_range(0, 600)) - 300));
        end
        drain();
    endtask

    initial begin
        wait_cycles(12);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_tables();
        test_random(460, 40'd2000, 40'd1500);
        test_random(460, 40'd0, 40'hFF_FFFF_FFFF);
        test_random(460, 40'd600, 40'd600);
        if (errors == 0) begin
            $display("pretrade_risk_limit_check_top regression: pass");
        end else begin
            $display("pretrade_risk_limit_check_top regression: fail");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/rlc_pkg.sv
rtl/rlc_ram.sv
rtl/rlc_ctrl.sv
rtl/rlc_datapath.sv
rtl/pretrade_risk_limit_check_top.sv
sim/pretrade_risk_limit_check_top_test.sv
